>>> rtl/tcc_pkg.sv
// Shared types and constants of the timecode continuity checker.
// Used by tcc_ctrl, tcc_dp and timecode_continuity_checker; no dependencies.
package tcc_pkg;

    localparam int HOURS_W      = 5;
    localparam int MINUTES_W    = 6;
    localparam int SECONDS_W    = 6;
    localparam int FRAME_W      = 7;
    localparam int RATE_W       = 7;
    localparam int CORR_W       = 9;
    localparam int SEQ_W        = 24;
    localparam int TIME_W       = 17;
    localparam int STUCK_W      = 8;
    localparam int SEEN_W       = 2;
    localparam int S_DATA_W     = 32;
    localparam int M_DATA_W     = 40;

    localparam int SECS_PER_DAY = 86400;
    localparam int SECS_PER_HR  = 3600;
    localparam int SECS_PER_MIN = 60;
    localparam int RATE_RESET   = 30;
    localparam int RATE_DUP_MAX = 30;
    localparam int STUCK_LIMIT  = 80;
    localparam int FORCED_SECS  = 61;

    // Remainder unit: one quotient bit per cycle over the 9-bit dividend.
    localparam int DIV_STEPS    = CORR_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    typedef struct packed {
        logic capture;
        logic times;
        logic mul;
        logic div_step;
        logic commit;
    } tcc_cmd_t;

    typedef struct packed {
        logic out_busy;
    } tcc_status_t;

endpackage

>>> rtl/tcc_ctrl.sv
// Sequencing state machine of the timecode continuity checker.
// Depends on tcc_pkg for the command and status structs.
module tcc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tcc_pkg::tcc_status_t status,
    output tcc_pkg::tcc_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TIME   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0]                   state_reg, state_next;
    logic [tcc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_TIME;
                end
            end
            ST_TIME: begin
                cmd.times  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == tcc_pkg::DIV_CNT_W'(tcc_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // Wait until the output register can take the result.
                if (!status.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/tcc_dp.sv
// Datapath of the timecode continuity checker: input capture, time and
// sequence arithmetic, bit-serial remainder, check logic, state and output.
// Depends on tcc_pkg; driven by tcc_ctrl through tcc_cmd_t.
module tcc_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tcc_pkg::RATE_W-1:0]      cfg_wr_data,
    input  logic [tcc_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcc_pkg::M_DATA_W-1:0]    m_tdata,
    input  tcc_pkg::tcc_cmd_t               cmd,
    output tcc_pkg::tcc_status_t            status
);

    localparam int HR_LO  = 0;
    localparam int MIN_LO = HR_LO + tcc_pkg::HOURS_W;
    localparam int SEC_LO = MIN_LO + tcc_pkg::MINUTES_W;
    localparam int FR_LO  = SEC_LO + tcc_pkg::SECONDS_W;
    localparam int FF_BIT = FR_LO + tcc_pkg::FRAME_W;

    // Configuration.
    logic [tcc_pkg::RATE_W-1:0]    rate_reg;

    // Captured item.
    logic [tcc_pkg::HOURS_W-1:0]   in_h_reg;
    logic [tcc_pkg::MINUTES_W-1:0] in_m_reg;
    logic [tcc_pkg::SECONDS_W-1:0] in_s_reg;
    logic [tcc_pkg::FRAME_W-1:0]   in_f_reg;
    logic                          in_force_reg;

    // Intermediate results.
    logic [tcc_pkg::TIME_W-1:0]    t2_reg, t1_reg;
    logic [tcc_pkg::SEQ_W-1:0]     seq_reg, seq_max_reg;
    logic [tcc_pkg::CORR_W-1:0]    plus1_reg, shift_reg;
    logic [7:0]                    rem_reg;

    // Kept state.
    logic [tcc_pkg::HOURS_W-1:0]   last_h_reg;
    logic [tcc_pkg::MINUTES_W-1:0] last_m_reg;
    logic [tcc_pkg::SECONDS_W-1:0] last_s_reg;
    logic [tcc_pkg::FRAME_W-1:0]   last_f_reg;
    logic [tcc_pkg::SEQ_W-1:0]     last_seq_reg;
    logic signed [tcc_pkg::CORR_W-1:0] last_corr_reg;
    logic [tcc_pkg::STUCK_W-1:0]   stuck_reg, stuck_next;
    logic [tcc_pkg::SEEN_W-1:0]    seen_reg;
    logic                          break_reg, break_next;

    // Output register.
    logic                          m_valid_reg;
    logic [tcc_pkg::M_DATA_W-1:0]  m_data_reg;

    // Combinational signals.
    logic [tcc_pkg::CORR_W-1:0]    rem_try;
    logic [tcc_pkg::TIME_W:0]      t1_plus;
    logic                          first, seq_bad, time_ok, frame_ok, disc;
    logic signed [tcc_pkg::CORR_W-1:0] corr;
    logic [tcc_pkg::CORR_W-1:0]    follow;

    assign status.out_busy = m_valid_reg && !m_tready;
    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;

    // One restoring step of the remainder (last_corrected + 1) mod frame_rate.
    assign rem_try = {rem_reg, shift_reg[tcc_pkg::CORR_W-1]};

    always_comb begin
        first = (seen_reg == '0);

        seq_bad = 1'b1;
        if (!first) begin
            if (last_seq_reg == seq_max_reg && seq_reg == '0) begin
                seq_bad = 1'b0;
            end else if ({1'b0, last_seq_reg} + 1'b1 == {1'b0, seq_reg}) begin
                seq_bad = 1'b0;
            end
        end

        if (rate_reg <= tcc_pkg::RATE_W'(tcc_pkg::RATE_DUP_MAX)) begin
            corr = signed'(tcc_pkg::CORR_W'(in_f_reg));
        end else if (in_f_reg == '0 && last_f_reg != '0) begin
            corr = '0;
        end else if (!last_corr_reg[tcc_pkg::CORR_W-1]) begin
            corr = (last_corr_reg == 9'sd255) ? last_corr_reg : last_corr_reg + 9'sd1;
        end else begin
            corr = '1;
        end

        // Time check and stuck counter.
        t1_plus    = {1'b0, t1_reg} + 1'b1;
        time_ok    = 1'b0;
        stuck_next = stuck_reg;
        if (t2_reg == t1_reg) begin
            time_ok = stuck_reg < tcc_pkg::STUCK_W'(tcc_pkg::STUCK_LIMIT);
            if (stuck_reg != '1) begin
                stuck_next = stuck_reg + 1'b1;
            end
        end else if ({1'b0, t2_reg} == t1_plus) begin
            time_ok    = 1'b1;
            stuck_next = '0;
        end else if (t1_plus >= (tcc_pkg::TIME_W + 1)'(tcc_pkg::SECS_PER_DAY) &&
                     {1'b0, t2_reg} ==
                     t1_plus - (tcc_pkg::TIME_W + 1)'(tcc_pkg::SECS_PER_DAY)) begin
            // Midnight wrap leaves the stuck counter alone.
            time_ok = 1'b1;
        end else begin
            stuck_next = '0;
        end

        follow   = (rate_reg == '0) ? plus1_reg : tcc_pkg::CORR_W'(rem_reg);
        frame_ok = (last_f_reg == in_f_reg) || (follow == corr) || (corr == '1);
        disc     = !(time_ok && frame_ok) || in_force_reg;

        break_next = first ? break_reg : (disc || seq_bad);
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_h_reg     <= s_tdata[HR_LO +: tcc_pkg::HOURS_W];
            in_m_reg     <= s_tdata[MIN_LO +: tcc_pkg::MINUTES_W];
            in_s_reg     <= s_tdata[SEC_LO +: tcc_pkg::SECONDS_W];
            in_f_reg     <= s_tdata[FR_LO +: tcc_pkg::FRAME_W];
            in_force_reg <= s_tdata[FF_BIT];
        end
        if (cmd.times) begin
            t2_reg <= tcc_pkg::TIME_W'(in_h_reg) * tcc_pkg::TIME_W'(tcc_pkg::SECS_PER_HR)
                    + tcc_pkg::TIME_W'(in_m_reg) * tcc_pkg::TIME_W'(tcc_pkg::SECS_PER_MIN)
                    + tcc_pkg::TIME_W'(in_s_reg);
            t1_reg <= tcc_pkg::TIME_W'(last_h_reg) * tcc_pkg::TIME_W'(tcc_pkg::SECS_PER_HR)
                    + tcc_pkg::TIME_W'(last_m_reg) * tcc_pkg::TIME_W'(tcc_pkg::SECS_PER_MIN)
                    + tcc_pkg::TIME_W'(last_s_reg);
            plus1_reg <= unsigned'(last_corr_reg) + 1'b1;
            shift_reg <= unsigned'(last_corr_reg) + 1'b1;
            rem_reg   <= '0;
        end
        if (cmd.mul) begin
            seq_reg     <= tcc_pkg::SEQ_W'(t2_reg) * tcc_pkg::SEQ_W'(rate_reg)
                         + tcc_pkg::SEQ_W'(in_f_reg);
            seq_max_reg <= tcc_pkg::SEQ_W'(tcc_pkg::SECS_PER_DAY) * tcc_pkg::SEQ_W'(rate_reg)
                         - 1'b1;
        end
        if (cmd.div_step) begin
            if (rem_try >= tcc_pkg::CORR_W'(rate_reg)) begin
                rem_reg <= 8'(rem_try - tcc_pkg::CORR_W'(rate_reg));
            end else begin
                rem_reg <= rem_try[7:0];
            end
            shift_reg <= {shift_reg[tcc_pkg::CORR_W-2:0], 1'b0};
        end
        if (cmd.commit) begin
            m_data_reg <= {{(tcc_pkg::M_DATA_W - 1 - tcc_pkg::CORR_W - tcc_pkg::SEQ_W){1'b0}},
                           seq_reg, unsigned'(corr), break_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg      <= tcc_pkg::RATE_W'(tcc_pkg::RATE_RESET);
            last_h_reg    <= '0;
            last_m_reg    <= '0;
            last_s_reg    <= '0;
            last_f_reg    <= '0;
            last_seq_reg  <= '0;
            last_corr_reg <= '1;
            stuck_reg     <= '0;
            seen_reg      <= '0;
            break_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rate_reg <= cfg_wr_data;
            end
            if (cmd.commit) begin
                last_h_reg    <= in_h_reg;
                last_m_reg    <= in_m_reg;
                last_s_reg    <= in_force_reg ? tcc_pkg::SECONDS_W'(tcc_pkg::FORCED_SECS)
                                              : in_s_reg;
                last_f_reg    <= in_f_reg;
                last_seq_reg  <= seq_reg;
                last_corr_reg <= corr;
                stuck_reg     <= stuck_next;
                if (seen_reg != 2'd2) begin
                    seen_reg <= seen_reg + 1'b1;
                end
                break_reg     <= break_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/timecode_continuity_checker.sv
// Timecode continuity checker: one result item for each timecode item. After an
// item is accepted the block forms the two times of day, then the sequence
// numbers with the frame-rate multiplier, then runs the bit-serial remainder unit
// that finds the expected follow-on frame, and then commits the check; the next
// item is accepted in the cycle after the commit. The result sits in an output
// register, so a stalled consumer only holds the block back when a second
// result is ready before the first has been taken. frame_rate is to be written
// through cfg_wr_en and cfg_wr_data only while the block is idle (the block does
// not enforce this) and resets to 30.
// Depends on tcc_pkg, tcc_ctrl and tcc_dp.
module timecode_continuity_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,  // frame_rate
    input  logic        s_tvalid,
    output logic        s_tready,
    // [4:0] hours, [10:5] minutes, [16:11] seconds, [23:17] frame_number,
    // [24] force_fault, [31:25] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] discontinuity, [9:1] adjusted_frame (signed), [33:10] sequence_number,
    // [39:34] zero
    output logic [39:0] m_tdata
);

    tcc_pkg::tcc_cmd_t    cmd;
    tcc_pkg::tcc_status_t status;

    tcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcc_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

    // An item is worked on alone: no second item right after an accept.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is still in work");

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(m_tvalid && !m_tready))
        else $error("result committed into a stalled output register");

    // A result only appears after a commit.
    a_valid_from_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("output valid without a commit");

    // The corrected frame is either -1 or in 0..255.
    a_corr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[9] |-> m_tdata[9:1] == 9'h1FF)
        else $error("corrected frame out of range");

endmodule

>>> sim/tcc_continuity_monitor.sv
// Watches both item channels and the frame_rate write port of the timecode
// continuity checker, predicts every result item and compares it field by field.
// Depends on tcc_pkg.
`timescale 1ns / 100ps

module tcc_continuity_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    output int          mismatch_count,
    output int          pending_results
);

    // Packed from the top bit down, so the last member sits in bit 0.
    typedef struct packed {
        logic [tcc_pkg::SEQ_W-1:0]  sequence_number;
        logic [tcc_pkg::CORR_W-1:0] adjusted_frame;
        logic                       discontinuity;
    } continuity_result_t;

    continuity_result_t expected_results[$];

    // Tracked copy of the block's state.
    int unsigned frame_rate;
    int unsigned prev_hours, prev_minutes, prev_seconds, prev_frame, prev_sequence;
    int          prev_corrected;
    int unsigned stuck_count, codes_seen;
    logic        break_flag;

    function automatic continuity_result_t predict_continuity(input logic [31:0] code);
        int unsigned hours, minutes, seconds, frame, day_secs, seq_num, day_end;
        int          corrected, now_secs, prev_secs, follow;
        logic        forced, first_code, seq_bad, time_ok, disc;
        continuity_result_t r;
        hours   = code[4:0];
        minutes = code[10:5];
        seconds = code[16:11];
        frame   = code[23:17];
        forced  = code[24];

        if (codes_seen < 2) codes_seen++;
        first_code = (codes_seen == 1);

        day_secs = seconds + minutes * tcc_pkg::SECS_PER_MIN + hours * tcc_pkg::SECS_PER_HR;
        seq_num  = (day_secs * frame_rate + frame) & 32'hFF_FFFF;
        day_end  = (tcc_pkg::SECS_PER_DAY * frame_rate - 1) & 32'hFF_FFFF;

        seq_bad = 1'b1;
        if (!first_code) begin
            if (prev_sequence == day_end && seq_num == 0)
                seq_bad = 1'b0;
            else if (prev_sequence + 1 == seq_num)
                seq_bad = 1'b0;
        end

        if (frame_rate <= tcc_pkg::RATE_DUP_MAX)
            corrected = frame;
        else if (frame == 0 && prev_frame != 0)
            corrected = 0;
        else if (prev_corrected >= 0)
            corrected = (prev_corrected < 255) ? prev_corrected + 1 : 255;
        else
            corrected = -1;

        now_secs  = int'(day_secs);
        prev_secs = int'(prev_hours * tcc_pkg::SECS_PER_HR
                         + prev_minutes * tcc_pkg::SECS_PER_MIN + prev_seconds);
        time_ok = 1'b0;
        if (now_secs == prev_secs) begin
            // The stuck count is tested before it moves on.
            if (stuck_count < tcc_pkg::STUCK_LIMIT) time_ok = 1'b1;
            if (stuck_count < 255) stuck_count++;
        end else if (now_secs - prev_secs == 1) begin
            time_ok = 1'b1;
            stuck_count = 0;
        end else if (now_secs == (prev_secs + 1) % tcc_pkg::SECS_PER_DAY) begin
            time_ok = 1'b1;
        end else begin
            stuck_count = 0;
        end

        if (time_ok) begin
            follow = prev_corrected + 1;
            if (frame_rate != 0) follow = follow % int'(frame_rate);
            if (prev_frame != frame && follow != corrected && corrected != -1)
                time_ok = 1'b0;
        end

        disc = !time_ok || forced;

        prev_hours     = hours;
        prev_minutes   = minutes;
        prev_seconds   = forced ? tcc_pkg::FORCED_SECS : seconds;
        prev_frame     = frame;
        prev_sequence  = seq_num;
        prev_corrected = corrected;
        if (!first_code) break_flag = disc || seq_bad;

        r.discontinuity   = break_flag;
        r.adjusted_frame  = corrected[tcc_pkg::CORR_W-1:0];
        r.sequence_number = seq_num[tcc_pkg::SEQ_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        continuity_result_t got, want;
        if (!aresetn) begin
            frame_rate      = tcc_pkg::RATE_RESET;
            prev_hours      = 0;
            prev_minutes    = 0;
            prev_seconds    = 0;
            prev_frame      = 0;
            prev_sequence   = 0;
            prev_corrected  = -1;
            stuck_count     = 0;
            codes_seen      = 0;
            break_flag      = 1'b0;
            mismatch_count  = 0;
            expected_results.delete();
        end else begin
            // Results are taken before new items are predicted, so a result can
            // never be matched against an item accepted at the same edge.
            if (m_tvalid && m_tready) begin
                got = m_tdata[33:0];
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation pending: %h", m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.discontinuity !== want.discontinuity) begin
                        $error("discontinuity: expected %0d, actual %0d",
                               want.discontinuity, got.discontinuity);
                        mismatch_count++;
                    end
                    if (got.adjusted_frame !== want.adjusted_frame) begin
                        $error("adjusted_frame: expected %0d, actual %0d",
                               $signed(want.adjusted_frame), $signed(got.adjusted_frame));
                        mismatch_count++;
                    end
                    if (got.sequence_number !== want.sequence_number) begin
                        $error("sequence_number: expected %0d, actual %0d",
                               want.sequence_number, got.sequence_number);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) frame_rate = cfg_wr_data;
            if (s_tvalid && s_tready) expected_results.push_back(predict_continuity(s_tdata));
        end
        pending_results = expected_results.size();
    end

endmodule

>>> sim/timecode_continuity_checker_tb.sv
// Top of the timecode continuity checker testbench: clock, reset, timecode
// streams at several frame rates, random stalls on both sides and the verdict.
// Depends on tcc_pkg, timecode_continuity_checker and tcc_continuity_monitor.
`timescale 1ns / 100ps

module timecode_continuity_checker_tb;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    int mismatches;
    int pending;

    // Generator state: the current timecode of the stream and the rate in use.
    int cur_h, cur_m, cur_s, cur_f;
    int rate_now;
    int send_burst_left;
    bit send_quiet;

    timecode_continuity_checker dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    tcc_continuity_monitor monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatches),
        .pending_results (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic send_timecode(input int h, input int m, input int s, input int f,
                                 input int forced);
        int gap;
        if (send_burst_left == 0) begin
            send_burst_left = $urandom_range(20, 60);
            send_quiet = ($urandom_range(0, 3) == 0);
        end
        send_burst_left--;
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {7'd0, 1'(forced), 7'(f), 6'(s), 6'(m), 5'(h)};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops offering items and returns once every expected result has come.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_frame_rate(input int rate);
        wait_for_results();
        // Let the block finish its last item before the register changes.
        repeat (20) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 7'(rate);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        rate_now = rate;
    endtask

    task automatic place_timecode(input int span, input int near_midnight);
        if (near_midnight != 0) begin
            cur_h = 23;
            cur_m = 59;
            cur_s = 59;
            cur_f = span - 1 - $urandom_range(0, (span > 3) ? 2 : span - 1);
        end else begin
            cur_h = $urandom_range(0, 23);
            cur_m = $urandom_range(0, 59);
            cur_s = $urandom_range(0, 59);
            cur_f = $urandom_range(0, span - 1);
        end
    endtask

    // Mostly well-formed codes with stuck seconds, jumps, forced faults and noise.
    task automatic run_timecode_stream(input int count, input bit doubled);
        int span, pick, reps, sent;
        span = doubled ? rate_now / 2 : rate_now;
        if (span < 1) span = 1;
        place_timecode(span, $urandom_range(0, 1));
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_timecode(cur_h, cur_m, cur_s, cur_f, 1);
                sent++;
            end else if (pick < 7) begin
                send_timecode($urandom_range(0, 31), $urandom_range(0, 63),
                              $urandom_range(0, 63), $urandom_range(0, 127),
                              $urandom_range(0, 1));
                sent++;
            end else if (pick < 10) begin
                place_timecode(span, $urandom_range(0, 1));
                send_timecode(cur_h, cur_m, cur_s, cur_f, 0);
                sent++;
            end else if (pick < 14) begin
                reps = $urandom_range(1, 8);
                repeat (reps) send_timecode(cur_h, cur_m, cur_s, cur_f, 0);
                sent += reps;
            end else begin
                cur_f++;
                if (cur_f >= span) begin
                    cur_f = 0;
                    cur_s++;
                    if (cur_s == 60) begin
                        cur_s = 0;
                        cur_m++;
                        if (cur_m == 60) begin
                            cur_m = 0;
                            cur_h = (cur_h == 23) ? 0 : cur_h + 1;
                        end
                    end
                end
                send_timecode(cur_h, cur_m, cur_s, cur_f, 0);
                sent++;
                if (doubled) begin
                    send_timecode(cur_h, cur_m, cur_s, cur_f, 0);
                    sent++;
                end
            end
        end
    endtask

    // Result side: random stalls per item, quiet stretches and one long hold-off.
    initial begin : result_sink
        int gap, burst_left, taken;
        bit quiet, held;
        m_tready = 1'b0;
        burst_left = 0;
        taken = 0;
        held = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!held && taken >= 500) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(20, 60);
                quiet = ($urandom_range(0, 3) == 0);
            end
            burst_left--;
            gap = quiet ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            taken++;
        end
    end

    initial begin : stimulus
        int phase_rates[10];
        bit doubled;
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = 7'd0;
        s_tvalid        = 1'b0;
        s_tdata         = 32'd0;
        rate_now        = tcc_pkg::RATE_RESET;
        send_burst_left = 0;
        send_quiet      = 1'b0;
        phase_rates     = '{1, 31, 60, 25, 120, 48, 24, 30, 50, 97};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset rate: first code at the day's last frame, then the midnight wrap,
        // a repeated frame, a forced fault and the field extremes.
        send_timecode(23, 59, 59, 29, 0);
        send_timecode(0, 0, 0, 0, 0);
        send_timecode(0, 0, 0, 1, 0);
        send_timecode(0, 0, 0, 1, 0);
        send_timecode(0, 0, 0, 2, 1);
        send_timecode(0, 0, 0, 3, 0);
        send_timecode(31, 63, 63, 127, 1);
        send_timecode(31, 63, 63, 127, 0);
        send_timecode(0, 0, 0, 0, 0);

        // Highest rate: corrected frame counts up by one per item until the frame field wraps.
        write_frame_rate(120);
        send_timecode(0, 0, 1, 5, 0);
        send_timecode(0, 0, 1, 5, 0);
        send_timecode(0, 0, 1, 0, 0);
        send_timecode(0, 0, 1, 0, 0);
        send_timecode(0, 0, 1, 1, 0);
        send_timecode(0, 0, 1, 2, 0);

        // Zero rate: follow-on frame without a modulus.
        write_frame_rate(0);
        send_timecode(1, 0, 0, 0, 0);
        send_timecode(1, 0, 0, 0, 0);
        send_timecode(1, 0, 0, 1, 0);
        send_timecode(1, 0, 1, 0, 0);

        // Lowest rate: the sequence number wraps at the day's end.
        write_frame_rate(1);
        send_timecode(23, 59, 58, 0, 0);
        send_timecode(23, 59, 59, 0, 0);
        send_timecode(0, 0, 0, 0, 0);

        // A long frozen code saturates both the stuck counter and the
        // corrected frame.
        write_frame_rate(120);
        send_timecode(0, 10, 0, 59, 0);
        repeat (272) send_timecode(0, 10, 1, 0, 0);

        for (int p = 0; p < 10; p++) begin
            write_frame_rate(phase_rates[p]);
            doubled = (rate_now > 30) && ($urandom_range(0, 1) == 1);
            if (p == 3) begin
                run_timecode_stream(75, doubled);
                wait_for_results();
                run_timecode_stream(80, doubled);
            end else begin
                run_timecode_stream(155, doubled);
            end
        end

        write_frame_rate(0);
        run_timecode_stream(30, 1'b0);

        wait_for_results();
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
